@@ rtl/ppbp_pkg.sv @@
// Shared types, constants and a helper function for the packed pattern byte parser.
package ppbp_pkg;

   // Flag byte bits that announce optional bytes of an entry
   localparam logic [7:0] FLAG_NOTE   = 8'h80;
   localparam logic [7:0] FLAG_INST   = 8'h40;
   localparam logic [7:0] FLAG_VOLUME = 8'h20;
   localparam logic [7:0] FLAG_CMD    = 8'h10;

   // Field values with special meaning
   localparam logic [7:0] BYTE_ABSENT  = 8'hff;
   localparam logic [7:0] VOLUME_LIMIT = 8'd65;
   localparam logic [7:0] CMD_BCD      = 8'h0d;

   // Entries held between the front and the back
   localparam int unsigned QUEUE_DEPTH = 2;

   typedef enum logic [2:0] {
      PH_HDR0  = 3'd0,
      PH_HDR1  = 3'd1,
      PH_FLAG  = 3'd2,
      PH_NOTE  = 3'd3,
      PH_INST  = 3'd4,
      PH_VOL   = 3'd5,
      PH_CMD   = 3'd6,
      PH_PARAM = 3'd7
   } phase_type;

   typedef enum logic [1:0] {
      EV_ENTRY     = 2'd0,
      EV_ROW_END   = 2'd1,
      EV_TRUNCATED = 2'd2
   } event_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       stream_end;
   } req_payload_type;

   typedef struct packed {
      event_type  event_kind;
      logic [5:0] row_index;
      logic [3:0] channel;
      logic       note_valid;
      logic [7:0] note_out;
      logic       inst_valid;
      logic [7:0] inst_number;
      logic       volume_valid;
      logic [6:0] volume_level;
      logic       effect_valid;
      logic [7:0] effect_cmd;
      logic [7:0] effect_param;
   } rsp_payload_type;

   // Classified beat handed from the front to the back: raw bytes of one event
   typedef struct packed {
      event_type  event_kind;
      logic [5:0] row_index;
      logic [3:0] channel;
      logic [7:0] note;
      logic [7:0] inst;
      logic [7:0] volume;
      logic [7:0] cmd;
      logic [7:0] param;
   } item_type;

   // Next phase that needs a byte after phase 'from', or PH_FLAG when the entry is done
   function automatic phase_type next_phase(input logic [7:0] flag, input phase_type from);
      phase_type nx;
      nx = PH_FLAG;
      if (from < PH_NOTE && (flag & FLAG_NOTE) != 8'h00) begin
         nx = PH_NOTE;
      end else if (from < PH_INST && (flag & FLAG_INST) != 8'h00) begin
         nx = PH_INST;
      end else if (from < PH_VOL && (flag & FLAG_VOLUME) != 8'h00) begin
         nx = PH_VOL;
      end else if (from < PH_CMD && (flag & FLAG_CMD) != 8'h00) begin
         nx = PH_CMD;
      end
      return nx;
   endfunction

endpackage

@@ rtl/ppbp_front.sv @@
// Front end: byte-wise parse state machine that classifies stream bytes into events.
module ppbp_front
   import ppbp_pkg::*;
#(
   parameter int unsigned ROWS_PER_PATTERN = 64
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_accept,
   input  req_payload_type in_payload,
   output logic            push,
   output item_type        push_item
);

   localparam int unsigned ROW_W = $clog2(ROWS_PER_PATTERN + 1);

   phase_type        phase_ff, phase_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [7:0]       flag_ff, flag_in;
   logic [7:0]       note_ff, note_in;
   logic [7:0]       inst_ff, inst_in;
   logic [7:0]       vol_ff, vol_in;
   logic [7:0]       cmd_ff, cmd_in;

   logic [ROW_W:0]   row_next;
   logic [ROW_W+5:0] row_wide;
   phase_type        nx;
   logic [7:0]       b;

   assign b        = in_payload.data_byte;
   assign row_next = {1'b0, row_ff} + {{ROW_W{1'b0}}, 1'b1};
   assign row_wide = {6'b0, row_ff};

   // Hold parse state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HDR0;
         row_ff   <= '0;
         flag_ff  <= 8'h00;
         note_ff  <= BYTE_ABSENT;
         inst_ff  <= BYTE_ABSENT;
         vol_ff   <= BYTE_ABSENT;
         cmd_ff   <= BYTE_ABSENT;
      end else begin
         phase_ff <= phase_in;
         row_ff   <= row_in;
         flag_ff  <= flag_in;
         note_ff  <= note_in;
         inst_ff  <= inst_in;
         vol_ff   <= vol_in;
         cmd_ff   <= cmd_in;
      end
   end

   // Advance the parser by one byte and classify the event it closes
   always_comb begin
      phase_in = phase_ff;
      row_in   = row_ff;
      flag_in  = flag_ff;
      note_in  = note_ff;
      inst_in  = inst_ff;
      vol_in   = vol_ff;
      cmd_in   = cmd_ff;
      nx       = PH_FLAG;
      push     = 1'b0;
      push_item.event_kind = EV_ENTRY;
      push_item.param      = 8'h00;

      if (in_accept) begin
         if (in_payload.stream_end) begin
            push                 = 1'b1;
            push_item.event_kind = EV_TRUNCATED;
            phase_in = PH_HDR0;
            row_in   = '0;
            flag_in  = 8'h00;
            note_in  = BYTE_ABSENT;
            inst_in  = BYTE_ABSENT;
            vol_in   = BYTE_ABSENT;
            cmd_in   = BYTE_ABSENT;
         end else begin
            case (phase_ff)
               PH_HDR0: begin
                  phase_in = PH_HDR1;
               end
               PH_HDR1: begin
                  phase_in = PH_FLAG;
               end
               PH_FLAG: begin
                  if (b == 8'h00) begin
                     push                 = 1'b1;
                     push_item.event_kind = EV_ROW_END;
                     if (row_next >= (ROW_W + 1)'(ROWS_PER_PATTERN)) begin
                        phase_in = PH_HDR0;
                        row_in   = '0;
                        flag_in  = 8'h00;
                        note_in  = BYTE_ABSENT;
                        inst_in  = BYTE_ABSENT;
                        vol_in   = BYTE_ABSENT;
                        cmd_in   = BYTE_ABSENT;
                     end else begin
                        row_in = row_next[ROW_W-1:0];
                     end
                  end else begin
                     flag_in  = b;
                     note_in  = BYTE_ABSENT;
                     inst_in  = BYTE_ABSENT;
                     vol_in   = BYTE_ABSENT;
                     cmd_in   = BYTE_ABSENT;
                     nx       = next_phase(b, PH_FLAG);
                     phase_in = nx;
                     push     = (nx == PH_FLAG);
                  end
               end
               PH_NOTE, PH_INST, PH_VOL: begin
                  if (phase_ff == PH_NOTE) begin
                     note_in = b;
                  end else if (phase_ff == PH_INST) begin
                     inst_in = b;
                  end else begin
                     vol_in = b;
                  end
                  nx       = next_phase(flag_ff, phase_ff);
                  phase_in = nx;
                  push     = (nx == PH_FLAG);
               end
               PH_CMD: begin
                  cmd_in   = b;
                  phase_in = PH_PARAM;
               end
               PH_PARAM: begin
                  phase_in        = PH_FLAG;
                  push            = 1'b1;
                  push_item.param = b;
               end
               default: begin
                  phase_in = PH_HDR0;
               end
            endcase
         end
      end

      push_item.row_index = row_wide[5:0];
      push_item.channel   = flag_in[3:0];
      push_item.note      = note_in;
      push_item.inst      = inst_in;
      push_item.volume    = vol_in;
      push_item.cmd       = cmd_in;
   end

   // Header bytes never close an event unless the stream ends
   a_hdr_silent: assert property (@(posedge clock) disable iff (reset)
      (push && (phase_ff == PH_HDR0 || phase_ff == PH_HDR1)) |-> in_payload.stream_end)
      else $error("event pushed from header phase without stream end");

   // Stream end always returns the parser to its first header phase
   a_end_restarts: assert property (@(posedge clock) disable iff (reset)
      (in_accept && in_payload.stream_end) |=> (phase_ff == PH_HDR0 && row_ff == '0))
      else $error("parser not restarted after stream end");

endmodule

@@ rtl/ppbp_queue.sv @@
// Short queue of classified events between the parser front and the formatter back.
module ppbp_queue
   import ppbp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   output logic     pop_valid,
   input  logic     pop,
   output item_type pop_item
);

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type         slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_item  = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   // Step pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the incoming beat
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into full queue");

endmodule

@@ rtl/ppbp_back.sv @@
// Back end: turns queued raw events into result beats held in an output register.
module ppbp_back
   import ppbp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            item_valid,
   input  item_type        item,
   output logic            pop,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff, fmt;
   logic [7:0]      bcd_value;
   logic            is_entry;

   assign pop         = item_valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;
   assign is_entry    = (item.event_kind == EV_ENTRY);

   // Two BCD digits to binary: high * 10 + low
   assign bcd_value = {1'b0, item.param[7:4], 3'b000} + {3'b000, item.param[7:4], 1'b0}
                    + {4'h0, item.param[3:0]};

   // Format one event; row end and error beats carry only kind and row
   always_comb begin
      fmt              = '0;
      fmt.event_kind   = item.event_kind;
      fmt.row_index    = item.row_index;
      if (is_entry) begin
         fmt.channel      = item.channel;
         fmt.note_valid   = (item.note != BYTE_ABSENT);
         fmt.note_out     = item.note + 8'd1;
         fmt.inst_valid   = (item.inst != 8'h00) && (item.inst != BYTE_ABSENT);
         fmt.inst_number  = item.inst;
         fmt.volume_valid = (item.volume < VOLUME_LIMIT);
         fmt.volume_level = (item.volume < VOLUME_LIMIT) ? item.volume[6:0] : 7'd0;
         fmt.effect_valid = (item.cmd != BYTE_ABSENT);
         fmt.effect_cmd   = item.cmd;
         if (item.cmd == BYTE_ABSENT) begin
            fmt.effect_param = 8'h00;
         end else if (item.cmd == CMD_BCD) begin
            fmt.effect_param = bcd_value;
         end else begin
            fmt.effect_param = item.param;
         end
      end
   end

   assign rsp_valid_in = pop ? 1'b1 : (rsp_valid_ff && !rsp_ready);

   // Hold the result until the receiver takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_payload_ff <= fmt;
      end
   end

   a_marker_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_payload_ff.event_kind != EV_ENTRY) |->
         (rsp_payload_ff.channel == 4'h0 && !rsp_payload_ff.note_valid &&
          !rsp_payload_ff.effect_valid && rsp_payload_ff.effect_param == 8'h00))
      else $error("row end or error beat carries entry fields");

   a_volume_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_payload_ff.volume_valid) |-> rsp_payload_ff.volume_level <= 7'd64)
      else $error("valid volume out of range");

endmodule

@@ rtl/packed_pattern_byte_parser.sv @@
// Top level of the packed pattern byte parser: front parser, event queue, result formatter.
//
// Usage:
//   req channel: one stream byte per beat (data_byte), or a beat with stream_end set
//   that closes the stream; its data byte is ignored.
//   rsp channel: at most one result beat per request beat: an entry, a row end,
//   or a truncated pattern error. Bytes that open or continue an entry give none.
//   Two header bytes are skipped, then entries are read until ROWS_PER_PATTERN
//   rows are complete; the parser then expects the header of the next pattern.
// Timing:
//   One request beat is taken every cycle while the queue is not full. A result
//   passes through a queue slot, then the output register, before it appears on
//   rsp; older results still waiting or a stalled receiver delay it further.
//   The queue holds two events.
// Reset:
//   Synchronous; the parser waits for the first header byte, the queue and
//   the output register are empty.
// Stall:
//   A result stays in the output register until taken; the queue keeps taking
//   beats until it holds two events, then req_ready drops.
module packed_pattern_byte_parser
   import ppbp_pkg::*;
#(
   parameter int unsigned ROWS_PER_PATTERN = 64
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   logic     in_accept;
   logic     push, full, q_valid, pop;
   item_type push_item, q_item;

   assign req_ready = !full;
   assign in_accept = req_valid && req_ready;

   // Parse bytes into events
   ppbp_front #(
      .ROWS_PER_PATTERN(ROWS_PER_PATTERN)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_accept  (in_accept),
      .in_payload (req_payload),
      .push       (push),
      .push_item  (push_item)
   );

   // Decouple parser from result formatter
   ppbp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (full),
      .pop_valid (q_valid),
      .pop       (pop),
      .pop_item  (q_item)
   );

   // Format and drive results
   ppbp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (q_valid),
      .item        (q_item),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

@@ tb/tb_packed_pattern_byte_parser.sv @@
// Self-checking testbench for the packed pattern byte parser: stimulus, predictor and checks.
module tb_packed_pattern_byte_parser;
   import ppbp_pkg::*;

   localparam int unsigned ROWS          = 64;
   localparam int          SETTLE_CYCLES = 10;
   localparam int          REPORT_CAP    = 100;

   // Predicts parser events from accepted bytes and checks them against result beats
   class parse_scoreboard;
      int unsigned     pattern_rows;
      int unsigned     mismatches;
      rsp_payload_type pending_events [$];
      phase_type       phase;
      int unsigned     rows_done;
      logic [7:0]      flag_byte;
      logic [7:0]      note_byte;
      logic [7:0]      inst_byte;
      logic [7:0]      vol_byte;
      logic [7:0]      cmd_byte;

      function new(int unsigned rows);
         pattern_rows = rows;
         mismatches   = 0;
         restart();
      endfunction

      // Return to the state after reset: wait for the first header byte
      function void restart();
         phase     = PH_HDR0;
         rows_done = 0;
         flag_byte = 8'h00;
         note_byte = BYTE_ABSENT;
         inst_byte = BYTE_ABSENT;
         vol_byte  = BYTE_ABSENT;
         cmd_byte  = BYTE_ABSENT;
      endfunction

      function int pending();
         return pending_events.size();
      endfunction

      // Next byte the entry still needs after phase 'from'; PH_FLAG once complete
      function phase_type wanted_after(logic [7:0] flag, phase_type from);
         phase_type nx;
         nx = PH_FLAG;
         if (flag[4] && from < PH_CMD) nx = PH_CMD;
         if (flag[5] && from < PH_VOL) nx = PH_VOL;
         if (flag[6] && from < PH_INST) nx = PH_INST;
         if (flag[7] && from < PH_NOTE) nx = PH_NOTE;
         return nx;
      endfunction

      // Format a finished entry from the held bytes
      function rsp_payload_type entry_event(logic [7:0] param);
         rsp_payload_type ev;
         ev = '0;
         ev.event_kind   = EV_ENTRY;
         ev.row_index    = rows_done[5:0];
         ev.channel      = flag_byte[3:0];
         ev.note_valid   = (note_byte != BYTE_ABSENT);
         ev.note_out     = note_byte + 8'd1;
         ev.inst_valid   = (inst_byte != 8'h00) && (inst_byte != BYTE_ABSENT);
         ev.inst_number  = inst_byte;
         ev.volume_valid = (vol_byte < VOLUME_LIMIT);
         ev.volume_level = (vol_byte < VOLUME_LIMIT) ? vol_byte[6:0] : 7'd0;
         ev.effect_valid = (cmd_byte != BYTE_ABSENT);
         ev.effect_cmd   = cmd_byte;
         if (cmd_byte == BYTE_ABSENT) begin
            ev.effect_param = 8'h00;
         end else if (cmd_byte == CMD_BCD) begin
            ev.effect_param = 8'((param[7:4] * 10) + param[3:0]);
         end else begin
            ev.effect_param = param;
         end
         return ev;
      endfunction

      // Advance the parser by one accepted beat and queue the event it yields
      function void parse_byte(req_payload_type beat);
         rsp_payload_type ev;
         logic [7:0]      b;
         ev = '0;
         b  = beat.data_byte;
         if (beat.stream_end) begin
            ev.event_kind = EV_TRUNCATED;
            ev.row_index  = rows_done[5:0];
            pending_events.push_back(ev);
            restart();
            return;
         end
         case (phase)
            PH_HDR0: begin
               phase = PH_HDR1;
            end
            PH_HDR1: begin
               phase = PH_FLAG;
            end
            PH_FLAG: begin
               if (b == 8'h00) begin
                  ev.event_kind = EV_ROW_END;
                  ev.row_index  = rows_done[5:0];
                  pending_events.push_back(ev);
                  rows_done++;
                  if (rows_done >= pattern_rows) restart();
               end else begin
                  // New entry: every field starts absent
                  flag_byte = b;
                  note_byte = BYTE_ABSENT;
                  inst_byte = BYTE_ABSENT;
                  vol_byte  = BYTE_ABSENT;
                  cmd_byte  = BYTE_ABSENT;
                  phase     = wanted_after(b, PH_FLAG);
                  if (phase == PH_FLAG) pending_events.push_back(entry_event(8'h00));
               end
            end
            PH_NOTE, PH_INST, PH_VOL: begin
               if (phase == PH_NOTE) note_byte = b;
               else if (phase == PH_INST) inst_byte = b;
               else vol_byte = b;
               phase = wanted_after(flag_byte, phase);
               if (phase == PH_FLAG) pending_events.push_back(entry_event(8'h00));
            end
            PH_CMD: begin
               cmd_byte = b;
               phase    = PH_PARAM;
            end
            default: begin
               phase = PH_FLAG;
               pending_events.push_back(entry_event(b));
            end
         endcase
      endfunction

      function void on_request(req_payload_type beat);
         parse_byte(beat);
      endfunction

      function void compare_field(string field, logic [7:0] want, logic [7:0] got);
         if (want !== got) begin
            mismatches++;
            // cap the log when the block is badly off
            if (mismatches <= REPORT_CAP)
               $display("%0t %s: expected %0h, got %0h", $time, field, want, got);
         end
      endfunction

      // Compare a result beat with the oldest expected event
      function void on_result(rsp_payload_type got);
         rsp_payload_type want;
         if (pending_events.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_CAP)
               $display("%0t unexpected result: expected none, got %0h", $time, got);
            return;
         end
         want = pending_events.pop_front();
         compare_field("event_kind", 8'(want.event_kind), 8'(got.event_kind));
         compare_field("row_index", 8'(want.row_index), 8'(got.row_index));
         compare_field("channel", 8'(want.channel), 8'(got.channel));
         compare_field("note_valid", 8'(want.note_valid), 8'(got.note_valid));
         compare_field("note_out", want.note_out, got.note_out);
         compare_field("inst_valid", 8'(want.inst_valid), 8'(got.inst_valid));
         compare_field("inst_number", want.inst_number, got.inst_number);
         compare_field("volume_valid", 8'(want.volume_valid), 8'(got.volume_valid));
         compare_field("volume_level", 8'(want.volume_level), 8'(got.volume_level));
         compare_field("effect_valid", 8'(want.effect_valid), 8'(got.effect_valid));
         compare_field("effect_cmd", want.effect_cmd, got.effect_cmd);
         compare_field("effect_param", want.effect_param, got.effect_param);
      endfunction
   endclass

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_ready;
   req_payload_type req_payload;
   logic            rsp_valid;
   logic            rsp_ready;
   rsp_payload_type rsp_payload;

   parse_scoreboard board;
   int              beats_sent;
   int              req_gap_pct;
   int              rsp_stall_pct;
   int              stall_left;

   packed_pattern_byte_parser #(
      .ROWS_PER_PATTERN(ROWS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Take result beats, check them, and stall in random bursts
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.on_result(rsp_payload);
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (rsp_stall_pct > 0 && $urandom_range(99, 0) < rsp_stall_pct) begin
         stall_left = $urandom_range(8, 0);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Drive one beat, with an optional idle burst first, and hold it until taken
   task automatic send_beat(input req_payload_type beat);
      if (req_gap_pct > 0 && $urandom_range(99, 0) < req_gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(9, 1)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= beat;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.on_request(beat);
      beats_sent++;
   endtask

   task automatic send_byte(input logic [7:0] b);
      req_payload_type beat;
      beat.data_byte  = b;
      beat.stream_end = 1'b0;
      send_beat(beat);
   endtask

   // Close the stream; the data byte rides along but is ignored
   task automatic send_end();
      req_payload_type beat;
      beat.data_byte  = 8'($urandom);
      beat.stream_end = 1'b1;
      send_beat(beat);
   endtask

   // Hold the sender until every expected event has come out
   task automatic wait_results_drained();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   // Send a flag byte and at most 'limit' of the bytes it announces
   task automatic send_entry(input logic [7:0] flag, note, inst, vol, cmd, param,
                             input int limit);
      logic [7:0] tail [$];
      if (flag[7]) tail.push_back(note);
      if (flag[6]) tail.push_back(inst);
      if (flag[5]) tail.push_back(vol);
      if (flag[4]) begin
         tail.push_back(cmd);
         tail.push_back(param);
      end
      send_byte(flag);
      for (int k = 0; k < tail.size() && k < limit; k++) send_byte(tail[k]);
   endtask

   // Bytes biased toward the values with special meaning
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(7, 0))
         0:       return BYTE_ABSENT;
         1:       return 8'h00;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] pick_volume();
      case ($urandom_range(7, 0))
         0:       return 8'd64;
         1:       return VOLUME_LIMIT;
         2:       return 8'($urandom);
         3:       return BYTE_ABSENT;
         default: return 8'($urandom_range(64, 0));
      endcase
   endfunction

   function automatic logic [7:0] pick_cmd();
      case ($urandom_range(5, 0))
         0, 1:    return CMD_BCD;
         2:       return BYTE_ABSENT;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic send_random_entry(input int limit);
      send_entry(8'($urandom_range(255, 1)), pick_byte(), pick_byte(), pick_volume(),
                 pick_cmd(), pick_byte(), limit);
   endtask

   // One pattern: header, rows of entries, row ends; sometimes cut short
   task automatic send_random_pattern();
      int cut_row;
      int entries;
      cut_row = ($urandom_range(3, 0) == 0) ? $urandom_range(ROWS - 1, 0) : ROWS;
      send_byte(8'($urandom));
      if (cut_row == 0 && $urandom_range(1, 0) == 0) begin
         send_end();
         return;
      end
      send_byte(8'($urandom));
      for (int r = 0; r < ROWS; r++) begin
         case ($urandom_range(19, 0))
            0, 1, 2, 3, 4, 5, 6, 7, 8, 9: entries = 0;
            10, 11, 12, 13, 14, 15, 16:   entries = 1;
            default:                      entries = $urandom_range(3, 2);
         endcase
         repeat (entries) send_random_entry(5);
         if (r == cut_row) begin
            // end the stream inside or right after an entry
            send_random_entry($urandom_range(4, 0));
            send_end();
            return;
         end
         send_byte(8'h00);
      end
      if ($urandom_range(4, 0) == 0) send_end();
   endtask

   // Unstructured bytes, then a stream end to resynchronize
   task automatic send_noise();
      repeat ($urandom_range(20, 3)) begin
         if ($urandom_range(11, 0) == 0) send_end();
         else send_byte(8'($urandom));
      end
      send_end();
   endtask

   task automatic send_random_chunk();
      if ($urandom_range(5, 0) == 0) send_noise();
      else send_random_pattern();
   endtask

   initial begin
      req_valid     = 1'b0;
      req_payload   = '0;
      reset         = 1'b1;
      beats_sent    = 0;
      req_gap_pct   = 30;
      rsp_stall_pct = 30;
      board         = new(ROWS);
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: stream end before any header byte
      send_end();
      send_byte(8'h00);
      send_byte(8'hff);
      // all fields on channel 15: absent note, instrument 0, full volume, BCD parameter
      send_entry(8'hff, 8'hff, 8'h00, 8'd64, CMD_BCD, 8'h99, 5);
      // flag with no optional bytes
      send_entry(8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 5);
      // absent command turns the effect and its parameter off
      send_entry(8'h1e, 8'h00, 8'h00, 8'h00, BYTE_ABSENT, 8'h37, 5);
      // note 0xfe becomes 0xff, instrument 0xff, volume just past the limit
      send_entry(8'he0, 8'hfe, 8'hff, VOLUME_LIMIT, 8'h00, 8'h00, 5);
      // BCD command with nibbles above nine
      send_entry(8'h90, 8'h00, 8'h00, 8'h00, CMD_BCD, 8'haf, 5);
      send_byte(8'h00);
      // stream end in the middle of an entry
      send_entry(8'ha3, 8'h7f, 8'h00, 8'h00, 8'h00, 8'h00, 1);
      send_end();
      wait_results_drained();

      // Random: idling on both sides
      req_gap_pct   = 15;
      rsp_stall_pct = 20;
      while (beats_sent < 450) send_random_chunk();
      wait_results_drained();

      // Random: heavy backpressure with a steady sender
      req_gap_pct   = 0;
      rsp_stall_pct = 50;
      while (beats_sent < 650) send_random_chunk();

      // Random: full rate, no idling
      req_gap_pct   = 0;
      rsp_stall_pct = 0;
      while (beats_sent < 830) send_random_chunk();

      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.mismatches == 0) begin
         $display("** packed_pattern_byte_parser: PASSED **");
      end else begin
         $display("** packed_pattern_byte_parser: FAILED **");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run
   initial begin
      #4000000;
      $display("** packed_pattern_byte_parser: FAILED **");
      $finish;
   end

endmodule
